// File: rtl/plt_pkg.sv
// ----------------------------------------------------------------------------
// plt_pkg
// Shared types and codes for the partition label table.
// ----------------------------------------------------------------------------
`default_nettype none

package plt_pkg;

  localparam int IN_W  = 64;
  localparam int OUT_W = 24;
  localparam int CFG_W = 12;

  typedef enum logic [3:0] {
    OP_ADD       = 4'd0,
    OP_MOVE      = 4'd1,
    OP_SINGLE    = 4'd2,
    OP_MERGE     = 4'd3,
    OP_REMOVE    = 4'd4,
    OP_CONTAINS  = 4'd5,
    OP_SAME      = 4'd6,
    OP_COUNT     = 4'd7,
    OP_COMPACT   = 4'd8,
    OP_EXTEND    = 4'd9,
    OP_ALLSINGLE = 4'd10,
    OP_ALLONE    = 4'd11,
    OP_BOUND     = 4'd12,
    OP_INIT      = 4'd13
  } plt_op_t;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_ELEM       = 3'd1;
  localparam logic [2:0] ST_ID         = 3'd2;
  localparam logic [2:0] ST_ASSIGNED   = 3'd3;
  localparam logic [2:0] ST_UNASSIGNED = 3'd4;
  localparam logic [2:0] ST_EXHAUSTED  = 3'd5;
  localparam logic [2:0] ST_FULL       = 3'd6;

  localparam logic [1:0] CFG_ELEMS    = 2'd0;
  localparam logic [1:0] CFG_ASSIGNED = 2'd1;
  localparam logic [1:0] CFG_LABEL    = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_RD2,
    S_EXEC,
    S_W_RD,
    S_W_EV,
    S_W_RM,
    S_W_DN,
    S_FILL
  } plt_state_t;

  typedef struct packed {
    logic cap;
    logic dec;
    logic rd_e1;
    logic rd_e2;
    logic w_rd;
    logic w_ev;
    logic dn_rd;
    logic w_dn;
    logic fill;
    logic exec;
  } plt_cmd_t;

  typedef struct packed {
    plt_op_t op;
    logic    walk_go;
    logic    fill_go;
    logic    idx_end;
    logic    mark;
    logic    out_free;
  } plt_stat_t;

endpackage

`default_nettype wire

// File: rtl/partition_label_table_top.sv
// ----------------------------------------------------------------------------
// partition_label_table_top
// Quick-find disjoint-set table with a stream command port and one result
// per command.
// ----------------------------------------------------------------------------
// Point commands step through the decode and execute states; same-subset adds
// a state for the second read. The element is read through the registered read
// port of the single element memory. Merge walks the elements with a read and
// an update state each. Count and compact walk with a read and an evaluate state
// per unassigned element and add remap and dense reads for an assigned element,
// chained through the element, remap and dense memories. Allsingle (when the ids
// fit), allone and init sweep one element per cycle. A result that waits on the
// output holds the next command back. There is no clearing pass after reset;
// the remap memory is made valid per walk by a cross-check against the dense
// memory.
`default_nettype none

module partition_label_table_top
  import plt_pkg::*;
#(
  parameter int MAX_ELEMENTS   = 1024,
  parameter int MAX_SUBSET_IDS = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // command, element, second_element, subset, second_subset, upper_bound
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // status, flag, has_value, value
  output logic      [OUT_W-1:0] out_tdata,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  plt_cmd_t  cmd;
  plt_stat_t stat;

  plt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .stat(stat), .cmd(cmd)
  );

  plt_dp #(.MAX_ELEMENTS(MAX_ELEMENTS), .MAX_SUBSET_IDS(MAX_SUBSET_IDS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_tdata(in_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

endmodule

`default_nettype wire

// File: rtl/plt_ram.sv
// ----------------------------------------------------------------------------
// plt_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module plt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/plt_ctrl.sv
// ----------------------------------------------------------------------------
// plt_ctrl
// Command sequencer: steps point operations, element walks and fill sweeps.
// ----------------------------------------------------------------------------
`default_nettype none

module plt_ctrl
  import plt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire plt_stat_t stat,
  output plt_cmd_t       cmd
);

  plt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DEC;
      end
      S_DEC: begin
        case (stat.op)
          OP_ADD, OP_MOVE, OP_SINGLE, OP_REMOVE, OP_CONTAINS: state_nxt = S_EXEC;
          OP_SAME:              state_nxt = S_RD2;
          OP_MERGE:             state_nxt = stat.walk_go ? S_W_RD : S_EXEC;
          OP_COUNT, OP_COMPACT: state_nxt = S_W_RD;
          OP_ALLSINGLE:         state_nxt = stat.fill_go ? S_FILL : S_EXEC;
          OP_ALLONE, OP_INIT:   state_nxt = S_FILL;
          default:              state_nxt = S_EXEC;
        endcase
      end
      S_RD2: state_nxt = S_EXEC;
      S_W_RD: begin
        state_nxt = stat.idx_end ? S_EXEC : S_W_EV;
      end
      S_W_EV: begin
        if (stat.op == OP_MERGE || !stat.mark) state_nxt = S_W_RD;
        else state_nxt = S_W_RM;
      end
      S_W_RM: state_nxt = S_W_DN;
      S_W_DN: state_nxt = S_W_RD;
      S_FILL: begin
        if (stat.idx_end) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.cap   = in_tvalid;
      end
      S_DEC: begin
        cmd.dec = 1'b1;
        case (stat.op)
          OP_ADD, OP_MOVE, OP_SINGLE, OP_REMOVE, OP_CONTAINS, OP_SAME: cmd.rd_e1 = 1'b1;
          default: cmd.rd_e1 = 1'b0;
        endcase
      end
      S_RD2:  cmd.rd_e2 = 1'b1;
      S_W_RD: cmd.w_rd  = !stat.idx_end;
      S_W_EV: cmd.w_ev  = 1'b1;
      S_W_RM: cmd.dn_rd = 1'b1;
      S_W_DN: cmd.w_dn  = 1'b1;
      S_FILL: cmd.fill  = !stat.idx_end;
      S_EXEC: cmd.exec  = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/plt_dp.sv
// ----------------------------------------------------------------------------
// plt_dp
// Datapath: element memory, remap memories, counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module plt_dp
  import plt_pkg::*;
#(
  parameter int MAX_ELEMENTS   = 1024,
  parameter int MAX_SUBSET_IDS = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire plt_cmd_t          cmd,
  output plt_stat_t              stat,
  input  wire logic [IN_W-1:0]   in_tdata,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [OUT_W-1:0]  out_tdata
);

  localparam int TOPV = (MAX_SUBSET_IDS > MAX_ELEMENTS) ? MAX_SUBSET_IDS : MAX_ELEMENTS;
  localparam int IW   = $clog2(TOPV + 1);
  localparam int EW1  = $clog2(MAX_ELEMENTS + 1);
  localparam int AW   = $clog2(MAX_ELEMENTS);
  localparam int SW   = $clog2(MAX_SUBSET_IDS);
  localparam int LW0  = (SW > 12) ? SW : 12;
  localparam int LW   = (AW > LW0) ? AW : LW0;
  localparam int RD   = 2 ** LW;

  logic [3:0]  op_r;
  logic [9:0]  e1_r, e2_r;
  logic [11:0] s_r, t_r;
  logic [12:0] ub_r;

  logic [10:0] cfg_elems_r;
  logic        cfg_assigned_r;
  logic [11:0] cfg_label_r;

  logic [EW1-1:0] ec_r, ec_nxt, idx_r, idx_nxt, k_r, k_nxt;
  logic [IW-1:0]  id_r, id_nxt;
  logic           pre_err_r, pre_err_nxt;
  logic [LW:0]    d1_r;

  logic           out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  logic           el_we, el_re;
  logic [AW-1:0]  el_wa, el_ra;
  logic [LW:0]    el_wd, el_rd;
  logic           rm_we, rm_re;
  logic [EW1-1:0] rm_rd;
  logic           dn_we, dn_re;
  logic [LW-1:0]  dn_rd;

  logic           mark;
  logic [LW-1:0]  lab;
  logic           ok1, ok2, s_ok, t_ok, fill_fit, walk_go, seen;
  logic [EW1-1:0] init_ec, newlab;
  logic [2:0]     st;
  logic           fl, hv;
  logic [IW-1:0]  val;
  plt_op_t        op;

  assign op    = plt_op_t'(op_r);
  assign mark  = el_rd[LW];
  assign lab   = el_rd[LW-1:0];
  assign ok1   = 32'(e1_r) < 32'(ec_r);
  assign ok2   = 32'(e2_r) < 32'(ec_r);
  assign s_ok  = 32'(s_r) < 32'(id_r);
  assign t_ok  = 32'(t_r) < 32'(id_r);
  assign fill_fit = (32'(id_r) + 32'(ec_r)) <= 32'(MAX_SUBSET_IDS);
  assign walk_go  = s_ok && t_ok && (s_r != t_r) && (32'(id_r) < 32'(MAX_SUBSET_IDS));
  assign init_ec  = (32'(cfg_elems_r) > 32'(MAX_ELEMENTS)) ? EW1'(MAX_ELEMENTS)
                                                          : EW1'(cfg_elems_r);
  assign seen     = (rm_rd < k_r) && (dn_rd == lab);

  assign stat.op       = op;
  assign stat.walk_go  = walk_go;
  assign stat.fill_go  = fill_fit;
  assign stat.idx_end  = idx_r >= ec_r;
  assign stat.mark     = mark;
  assign stat.out_free = !out_valid_r || out_tready;

  always_comb begin
    el_we = 1'b0;
    el_wa = AW'(e1_r);
    el_wd = '0;
    el_re = 1'b0;
    el_ra = AW'(e1_r);
    rm_we = 1'b0;
    rm_re = 1'b0;
    dn_we = 1'b0;
    dn_re = 1'b0;
    newlab = k_r;
    id_nxt = id_r;
    ec_nxt = ec_r;
    idx_nxt = idx_r;
    k_nxt = k_r;
    pre_err_nxt = pre_err_r;
    st = ST_OK;
    fl = 1'b0;
    hv = 1'b0;
    val = '0;

    if (cmd.rd_e1) begin
      el_re = 1'b1;
    end
    if (cmd.rd_e2) begin
      el_re = 1'b1;
      el_ra = AW'(e2_r);
    end
    if (cmd.w_rd) begin
      el_re = 1'b1;
      el_ra = AW'(idx_r);
    end
    if (cmd.dec) begin
      idx_nxt = '0;
      k_nxt = '0;
      pre_err_nxt = !fill_fit;
      if (op == OP_INIT) ec_nxt = init_ec;
    end
    if (cmd.w_ev) begin
      el_wa = AW'(idx_r);
      if (op == OP_MERGE) begin
        if (mark && (lab == LW'(s_r) || lab == LW'(t_r))) begin
          el_we = 1'b1;
          el_wd = {1'b1, LW'(id_r)};
        end
        idx_nxt = idx_r + 1'b1;
      end else if (!mark) begin
        idx_nxt = idx_r + 1'b1;
      end else begin
        rm_re = 1'b1;
      end
    end
    if (cmd.dn_rd) begin
      dn_re = 1'b1;
    end
    if (cmd.w_dn) begin
      if (seen) begin
        newlab = rm_rd;
      end else begin
        rm_we = 1'b1;
        dn_we = 1'b1;
        k_nxt = k_r + 1'b1;
      end
      el_wa = AW'(idx_r);
      el_we = (op == OP_COMPACT);
      el_wd = {1'b1, LW'(newlab)};
      idx_nxt = idx_r + 1'b1;
    end
    if (cmd.fill) begin
      el_we = 1'b1;
      el_wa = AW'(idx_r);
      idx_nxt = idx_r + 1'b1;
      case (op)
        OP_ALLSINGLE: begin
          el_wd = {1'b1, LW'(id_r)};
          id_nxt = id_r + 1'b1;
        end
        OP_INIT: el_wd = {cfg_assigned_r, LW'(cfg_label_r)};
        default: el_wd = {1'b1, {LW{1'b0}}};
      endcase
    end
    if (cmd.exec) begin
      case (op)
        OP_ADD, OP_MOVE: begin
          if (!ok1) st = ST_ELEM;
          else if (op == OP_ADD && mark) st = ST_ASSIGNED;
          else if (op == OP_MOVE && !mark) st = ST_UNASSIGNED;
          else if (!s_ok) st = ST_ID;
          else begin
            el_we = 1'b1;
            el_wd = {1'b1, LW'(s_r)};
          end
        end
        OP_SINGLE: begin
          if (!ok1) st = ST_ELEM;
          else if (32'(id_r) >= 32'(MAX_SUBSET_IDS)) st = ST_EXHAUSTED;
          else begin
            el_we = 1'b1;
            el_wd = {1'b1, LW'(id_r)};
            hv = 1'b1;
            val = id_r;
            id_nxt = id_r + 1'b1;
          end
        end
        OP_MERGE: begin
          if (!s_ok || !t_ok) st = ST_ID;
          else if (s_r != t_r) begin
            if (32'(id_r) >= 32'(MAX_SUBSET_IDS)) st = ST_EXHAUSTED;
            else begin
              hv = 1'b1;
              val = id_r;
              id_nxt = id_r + 1'b1;
            end
          end
        end
        OP_REMOVE: begin
          if (!ok1) st = ST_ELEM;
          else begin
            el_we = 1'b1;
            el_wd = {1'b0, lab};
          end
        end
        OP_CONTAINS: fl = ok1 && mark;
        OP_SAME: begin
          if (!ok1 || !ok2) st = ST_ELEM;
          else if (!d1_r[LW] || !mark) st = ST_UNASSIGNED;
          else fl = (d1_r[LW-1:0] == lab);
        end
        OP_COUNT: begin
          hv = 1'b1;
          val = IW'(k_r);
        end
        OP_COMPACT: begin
          hv = 1'b1;
          val = IW'(k_r);
          id_nxt = IW'(k_r);
        end
        OP_EXTEND: begin
          if (32'(ec_r) >= 32'(MAX_ELEMENTS)) st = ST_FULL;
          else begin
            el_we = 1'b1;
            el_wa = AW'(ec_r);
            el_wd = '0;
            hv = 1'b1;
            val = IW'(ec_r);
            ec_nxt = ec_r + 1'b1;
          end
        end
        OP_ALLSINGLE: st = pre_err_r ? ST_EXHAUSTED : ST_OK;
        OP_ALLONE, OP_INIT: id_nxt = IW'(1);
        OP_BOUND: begin
          if (32'(ub_r) > 32'(MAX_SUBSET_IDS)) st = ST_ID;
          else id_nxt = IW'(ub_r);
        end
        default: st = ST_OK;
      endcase
    end
  end

  plt_ram #(.WIDTH(LW + 1), .DEPTH(MAX_ELEMENTS)) u_elem (
    .clk(clk), .we(el_we), .waddr(el_wa), .wdata(el_wd),
    .re(el_re), .raddr(el_ra), .rdata(el_rd)
  );

  plt_ram #(.WIDTH(EW1), .DEPTH(RD)) u_remap (
    .clk(clk), .we(rm_we), .waddr(lab), .wdata(k_r),
    .re(rm_re), .raddr(lab), .rdata(rm_rd)
  );

  plt_ram #(.WIDTH(LW), .DEPTH(MAX_ELEMENTS)) u_dense (
    .clk(clk), .we(dn_we), .waddr(AW'(k_r)), .wdata(lab),
    .re(dn_re), .raddr(AW'(rm_rd)), .rdata(dn_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r <= in_tdata[3:0];
      e1_r <= in_tdata[13:4];
      e2_r <= in_tdata[23:14];
      s_r  <= in_tdata[35:24];
      t_r  <= in_tdata[47:36];
      ub_r <= in_tdata[60:48];
    end
    if (cmd.rd_e2) d1_r <= el_rd;
    idx_r     <= idx_nxt;
    k_r       <= k_nxt;
    pre_err_r <= pre_err_nxt;
    if (cmd.exec) out_data_r <= {6'b0, 13'(val), hv, fl, st};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_elems_r    <= '0;
      cfg_assigned_r <= 1'b0;
      cfg_label_r    <= '0;
      ec_r           <= '0;
      id_r           <= IW'(1);
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ELEMS:    cfg_elems_r    <= cfg_wdata[10:0];
          CFG_ASSIGNED: cfg_assigned_r <= cfg_wdata[0];
          CFG_LABEL:    cfg_label_r    <= cfg_wdata;
          default:      cfg_label_r    <= cfg_label_r;
        endcase
      end
      ec_r <= ec_nxt;
      id_r <= id_nxt;
      if (cmd.exec) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/plt_chk.sv
// ----------------------------------------------------------------------------
// plt_chk
// Port checks on the result channel of the partition label table.
// ----------------------------------------------------------------------------
`default_nettype none

module plt_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] != 3'd7)
    else $error("undefined status code");

  a_novalue: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[4] |-> out_tdata[17:5] == 13'd0)
    else $error("value without has_value");

  a_flag_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != 3'd0 |-> !out_tdata[3] && !out_tdata[4])
    else $error("answer given with error status");

endmodule

bind partition_label_table_top plt_chk u_plt_chk (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata)
);

`default_nettype wire

// File: test/tb_partition_label_table_top.sv
// ----------------------------------------------------------------------------
// tb_partition_label_table_top
// Self-checking bench for the partition label table. Commands go in on the
// input stream. A scoreboard keeps its own copy of the labels, marks, counts
// and registers, predicts each result, and compares every output field. The
// run steps through several register settings and idle/stall patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_partition_label_table_top;
  import plt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ELEM = 1024;
  localparam int N_IDS  = 4096;

  typedef struct packed {
    logic [3:0]  op;
    logic [9:0]  e1;
    logic [9:0]  e2;
    logic [11:0] s;
    logic [11:0] t;
    logic [12:0] ub;
  } plt_cmd_item_t;

  typedef struct packed {
    logic [12:0] value;
    logic        has_value;
    logic        flag;
    logic [2:0]  status;
  } plt_result_t;

  class plt_scoreboard;
    logic [11:0]  labels[N_ELEM];
    bit           marks[N_ELEM];
    int unsigned  elems;
    int unsigned  ids;
    int unsigned  cfg_elems;
    bit           cfg_assigned;
    logic [11:0]  cfg_label;
    plt_result_t  pending[$];
    int unsigned  mismatches;
    int unsigned  op_seen[16];

    function new();
      foreach (marks[i]) marks[i] = 0;
      elems = 0;
      ids = 1;
      cfg_elems = 0;
      cfg_assigned = 0;
      cfg_label = 0;
      mismatches = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_ELEMS:    cfg_elems = 32'(val[10:0]);
        CFG_ASSIGNED: cfg_assigned = val[0];
        CFG_LABEL:    cfg_label = val[11:0];
        default: ;
      endcase
    endfunction

    function bit elem_ok(logic [9:0] e);
      return 32'(e) < elems;
    endfunction

    function void note_command(plt_cmd_item_t c);
      plt_result_t r;
      int unsigned k;
      bit seen[N_IDS];
      logic [11:0] remap[N_IDS];
      r = '0;
      op_seen[c.op]++;
      case (c.op)
        OP_ADD, OP_MOVE: begin
          if (!elem_ok(c.e1)) r.status = ST_ELEM;
          else if (c.op == OP_ADD && marks[c.e1]) r.status = ST_ASSIGNED;
          else if (c.op == OP_MOVE && !marks[c.e1]) r.status = ST_UNASSIGNED;
          else if (32'(c.s) >= ids) r.status = ST_ID;
          else begin
            labels[c.e1] = c.s;
            marks[c.e1] = 1;
          end
        end
        OP_SINGLE: begin
          if (!elem_ok(c.e1)) r.status = ST_ELEM;
          else if (ids >= N_IDS) r.status = ST_EXHAUSTED;
          else begin
            labels[c.e1] = ids[11:0];
            marks[c.e1] = 1;
            r.has_value = 1;
            r.value = ids[12:0];
            ids++;
          end
        end
        OP_MERGE: begin
          if (32'(c.s) >= ids || 32'(c.t) >= ids) r.status = ST_ID;
          else if (c.s != c.t) begin
            if (ids >= N_IDS) r.status = ST_EXHAUSTED;
            else begin
              for (int e = 0; e < elems; e++)
                if (marks[e] && (labels[e] == c.s || labels[e] == c.t))
                  labels[e] = ids[11:0];
              r.has_value = 1;
              r.value = ids[12:0];
              ids++;
            end
          end
        end
        OP_REMOVE: begin
          if (!elem_ok(c.e1)) r.status = ST_ELEM;
          else marks[c.e1] = 0;
        end
        OP_CONTAINS: r.flag = elem_ok(c.e1) && marks[c.e1];
        OP_SAME: begin
          if (!elem_ok(c.e1) || !elem_ok(c.e2)) r.status = ST_ELEM;
          else if (!marks[c.e1] || !marks[c.e2]) r.status = ST_UNASSIGNED;
          else r.flag = labels[c.e1] == labels[c.e2];
        end
        OP_COUNT, OP_COMPACT: begin
          foreach (seen[i]) seen[i] = 0;
          k = 0;
          for (int e = 0; e < elems; e++) begin
            if (!marks[e]) continue;
            if (!seen[labels[e]]) begin
              seen[labels[e]] = 1;
              remap[labels[e]] = k[11:0];
              k++;
            end
            if (c.op == OP_COMPACT) labels[e] = remap[labels[e]];
          end
          if (c.op == OP_COMPACT) ids = k;
          r.has_value = 1;
          r.value = k[12:0];
        end
        OP_EXTEND: begin
          if (elems >= N_ELEM) r.status = ST_FULL;
          else begin
            marks[elems] = 0;
            labels[elems] = '0;
            r.has_value = 1;
            r.value = elems[12:0];
            elems++;
          end
        end
        OP_ALLSINGLE: begin
          if (ids + elems > N_IDS) r.status = ST_EXHAUSTED;
          else begin
            for (int e = 0; e < elems; e++) begin
              labels[e] = ids[11:0];
              marks[e] = 1;
              ids++;
            end
          end
        end
        OP_ALLONE: begin
          for (int e = 0; e < elems; e++) begin
            labels[e] = '0;
            marks[e] = 1;
          end
          ids = 1;
        end
        OP_BOUND: begin
          if (32'(c.ub) > N_IDS) r.status = ST_ID;
          else ids = 32'(c.ub);
        end
        OP_INIT: begin
          elems = cfg_elems > N_ELEM ? N_ELEM : cfg_elems;
          for (int e = 0; e < elems; e++) begin
            labels[e] = cfg_label;
            marks[e] = cfg_assigned;
          end
          ids = 1;
        end
        default: ;
      endcase
      pending = {pending, r};
    endfunction

    function void check_result(logic [OUT_W-1:0] d);
      plt_result_t got;
      plt_result_t exp_r;
      got = d[17:0];
      if (pending.size() == 0) begin
        $error("result with no command outstanding: %h", d);
        mismatches++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.status != exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, got.status);
        mismatches++;
      end
      if (got.flag != exp_r.flag) begin
        $error("flag: expected %0d, got %0d", exp_r.flag, got.flag);
        mismatches++;
      end
      if (got.has_value != exp_r.has_value) begin
        $error("has_value: expected %0d, got %0d", exp_r.has_value, got.has_value);
        mismatches++;
      end
      if (got.value != exp_r.value) begin
        $error("value: expected %0d, got %0d", exp_r.value, got.value);
        mismatches++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  plt_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;

  partition_label_table_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial clk = 0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic send_cmd(plt_cmd_item_t c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {3'b000, c.ub, c.t, c.s, c.e2, c.e1, c.op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_command(c);
  endtask

  task automatic send_op(plt_op_t op, int e1 = 0, int e2 = 0, int s = 0, int t = 0,
                         int ub = 0);
    plt_cmd_item_t c;
    c.op = op;
    c.e1 = 10'(e1);
    c.e2 = 10'(e2);
    c.s = 12'(s);
    c.t = 12'(t);
    c.ub = 13'(ub);
    send_cmd(c);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    drain();
    repeat (8) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, CFG_W'(val));
  endtask

  function automatic int pick_elem();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, sb.elems);
    return $urandom_range(0, 1023);
  endfunction

  function automatic int pick_id();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, sb.ids);
    return $urandom_range(0, 4095);
  endfunction

  function automatic plt_cmd_item_t random_cmd();
    plt_cmd_item_t c;
    int w;
    w = $urandom_range(0, 99);
    if (w < 12) c.op = OP_ADD;
    else if (w < 22) c.op = OP_MOVE;
    else if (w < 35) c.op = OP_SINGLE;
    else if (w < 41) c.op = OP_MERGE;
    else if (w < 49) c.op = OP_REMOVE;
    else if (w < 57) c.op = OP_CONTAINS;
    else if (w < 67) c.op = OP_SAME;
    else if (w < 70) c.op = OP_COUNT;
    else if (w < 73) c.op = OP_COMPACT;
    else if (w < 79) c.op = OP_EXTEND;
    else if (w < 81) c.op = OP_ALLSINGLE;
    else if (w < 83) c.op = OP_ALLONE;
    else if (w < 91) c.op = OP_BOUND;
    else if (w < 93) c.op = OP_INIT;
    else if (w < 95) c.op = 4'($urandom_range(14, 15));
    else c.op = OP_ADD;
    c.e1 = 10'(pick_elem());
    c.e2 = 10'(pick_elem());
    c.s = 12'(pick_id());
    c.t = ($urandom_range(0, 3) == 0) ? c.s : 12'(pick_id());
    w = $urandom_range(0, 9);
    if (w < 5) c.ub = 13'($urandom_range(0, 64));
    else if (w < 7) c.ub = 13'($urandom_range(4090, 4096));
    else c.ub = 13'($urandom_range(0, 8191));
    return c;
  endfunction

  initial begin
    int cfg_sets[6][3];
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    out_tready = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_wdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    sb = new();
    cfg_sets = '{'{1024, 1, 4095}, '{20, 0, 0}, '{40, 1, 7},
                 '{2047, 0, 2730}, '{5, 1, 1365}, '{64, 0, 100}};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_op(OP_INIT);
    send_op(OP_EXTEND);
    send_op(OP_EXTEND);
    send_op(OP_EXTEND);
    send_op(OP_ADD, 0, 0, 0);
    send_op(OP_ADD, 0, 0, 0);
    send_op(OP_ADD, 1023);
    send_op(OP_MOVE, 1);
    send_op(OP_ADD, 1, 0, 4095);
    send_op(OP_SINGLE, 1);
    send_op(OP_SINGLE, 2);
    send_op(OP_SAME, 1, 2);
    send_op(OP_SAME, 0, 1);
    send_op(OP_SAME, 0, 1023);
    send_op(OP_MERGE, 0, 0, 1, 2);
    send_op(OP_MERGE, 0, 0, 3, 3);
    send_op(OP_MERGE, 0, 0, 4095, 0);
    send_op(OP_CONTAINS, 2);
    send_op(OP_CONTAINS, 1023);
    send_op(OP_COUNT);
    send_op(OP_REMOVE, 0);
    send_op(OP_COMPACT);
    send_op(OP_BOUND, 0, 0, 0, 0, 4096);
    send_op(OP_SINGLE, 0);
    send_op(OP_ALLSINGLE);
    send_op(OP_BOUND, 0, 0, 0, 0, 8191);
    send_op(OP_BOUND, 0, 0, 0, 0, 0);
    send_op(OP_MERGE, 0, 0, 0, 0);
    send_op(OP_ALLSINGLE);
    send_op(OP_ALLONE);
    send_op(OP_REMOVE, 0);
    send_op(OP_COMPACT);
    send_op(OP_REMOVE, 1);
    send_op(OP_REMOVE, 2);
    send_op(OP_COMPACT);
    send_op(plt_op_t'(4'd14));
    send_op(plt_op_t'(4'd15), 1023, 1023, 4095, 4095, 8191);

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_ELEMS, cfg_sets[ph][0]);
      write_reg(CFG_ASSIGNED, cfg_sets[ph][1]);
      write_reg(CFG_LABEL, cfg_sets[ph][2]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      send_op(OP_INIT);
      send_op(OP_EXTEND);
      if (ph == 0) hold_left = 400;
      for (int i = 0; i < 210; i++) begin
        if (i == 105) drain();
        send_cmd(random_cmd());
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Covered %0d commands across 6 register settings and 4 idle/stall mixes.",
             sb.op_seen.sum());
    $display("Commands by code: %p", sb.op_seen);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #30ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
rtl/plt_pkg.sv
rtl/plt_ram.sv
rtl/plt_ctrl.sv
rtl/plt_dp.sv
rtl/partition_label_table_top.sv
rtl/plt_chk.sv
test/tb_partition_label_table_top.sv
